// File: sv/four_class_round_robin_queues_macros.svh
// assertion macros for the round-robin queue block
`ifndef FOUR_CLASS_ROUND_ROBIN_QUEUES_MACROS_SVH
`define FOUR_CLASS_ROUND_ROBIN_QUEUES_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCRR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcrr same-cycle check failed");

// next-cycle implication, checked outside reset
`define FCRR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcrr next-cycle check failed");

`endif

// File: sv/fcrr_pkg.sv
`timescale 1ns / 1ps
package fcrr_pkg;
   localparam int CLASS_COUNT     = 4;
   localparam int CLASS_W         = 2;
   localparam int ID_W            = 40;
   localparam int STATUS_W        = 2;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_CHARS_DEF    = 5;

   // transaction modes
   localparam logic MODE_ENQ   = 1'b0;
   localparam logic MODE_SERVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_ENQ    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DROP   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SERVED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

   // decision handed from the scheduler to the datapath
   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  cls;
   } fcrr_dec_type;
endpackage

// File: sv/fcrr_ram.sv
`timescale 1ns / 1ps
module fcrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/fcrr_sched.sv
`timescale 1ns / 1ps
module fcrr_sched #(
   parameter int QUEUE_DEPTH = fcrr_pkg::QUEUE_DEPTH_DEF,
   localparam int SLOT_W = $clog2(QUEUE_DEPTH),
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic                         mode,
   input  logic [fcrr_pkg::CLASS_W-1:0] queue_class,
   output fcrr_pkg::fcrr_dec_type       dec,
   output logic [SLOT_W-1:0]            slot
);
   localparam int NCLS = fcrr_pkg::CLASS_COUNT;

   logic [SLOT_W-1:0]            head_ff [NCLS];
   logic [SLOT_W-1:0]            head_in [NCLS];
   logic [SLOT_W-1:0]            tail_ff [NCLS];
   logic [SLOT_W-1:0]            tail_in [NCLS];
   logic [CNT_W-1:0]             fill_ff [NCLS];
   logic [CNT_W-1:0]             fill_in [NCLS];
   logic [fcrr_pkg::CLASS_W-1:0] ptr_ff;
   logic [fcrr_pkg::CLASS_W-1:0] ptr_in;
   logic [fcrr_pkg::CLASS_W-1:0] sel;
   logic                         found;
   logic                         full;

   // cyclic search for the first non-empty class from the service pointer
   always_comb begin
      logic [fcrr_pkg::CLASS_W-1:0] c;
      found = 1'b0;
      sel   = ptr_ff;
      c     = ptr_ff;
      for (int k = 0; k < NCLS; k++) begin
         c = ptr_ff + fcrr_pkg::CLASS_W'(k);
         if (!found && (fill_ff[c] != '0)) begin
            found = 1'b1;
            sel   = c;
         end
      end
   end

   assign full = (fill_ff[queue_class] == CNT_W'(QUEUE_DEPTH));

   // decision for the transaction at the port
   always_comb begin
      if (mode == fcrr_pkg::MODE_ENQ) begin
         dec.cls    = queue_class;
         dec.wr_en  = go && !full;
         dec.rd_en  = 1'b0;
         dec.status = full ? fcrr_pkg::STAT_DROP : fcrr_pkg::STAT_ENQ;
         slot       = tail_ff[queue_class];
      end else begin
         dec.cls    = sel;
         dec.wr_en  = 1'b0;
         dec.rd_en  = go && found;
         dec.status = found ? fcrr_pkg::STAT_SERVED : fcrr_pkg::STAT_EMPTY;
         slot       = head_ff[sel];
      end
   end

   // pointer and count updates, index wraps at the queue depth
   always_comb begin
      for (int i = 0; i < NCLS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         fill_in[i] = fill_ff[i];
      end
      ptr_in = ptr_ff;
      if (dec.wr_en) begin
         tail_in[dec.cls] = (tail_ff[dec.cls] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                            : tail_ff[dec.cls] + SLOT_W'(1);
         fill_in[dec.cls] = fill_ff[dec.cls] + CNT_W'(1);
      end
      if (dec.rd_en) begin
         head_in[dec.cls] = (head_ff[dec.cls] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                            : head_ff[dec.cls] + SLOT_W'(1);
         fill_in[dec.cls] = fill_ff[dec.cls] - CNT_W'(1);
         ptr_in           = dec.cls + fcrr_pkg::CLASS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCLS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         ptr_ff <= '0;
      end else begin
         for (int i = 0; i < NCLS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            fill_ff[i] <= fill_in[i];
         end
         ptr_ff <= ptr_in;
      end
   end
endmodule

// File: sv/four_class_round_robin_queues.sv
`timescale 1ns / 1ps
// channel | direction | ports
// req     | in        | req_valid req_ready req_mode req_queue_class req_item_id
// rsp     | out       | rsp_valid rsp_ready rsp_status rsp_served_id rsp_served_class
//
// each transaction is decided and accesses the entry memory, then its result
// is registered from the memory's registered read port.
// a new request is taken only when none is pending and the result register is free or being drained.
// reset clears pointers, counts and valid flags; entries need no clearing.
// a stalled result holds in the output register and blocks new requests.
`include "four_class_round_robin_queues_macros.svh"
module four_class_round_robin_queues #(
   parameter int QUEUE_DEPTH = fcrr_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_CHARS    = fcrr_pkg::ID_CHARS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [fcrr_pkg::CLASS_W-1:0]  req_queue_class,
   input  logic [fcrr_pkg::ID_W-1:0]     req_item_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fcrr_pkg::STATUS_W-1:0] rsp_status,
   output logic [fcrr_pkg::ID_W-1:0]     rsp_served_id,
   output logic [fcrr_pkg::CLASS_W-1:0]  rsp_served_class
);
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W  = fcrr_pkg::CLASS_W + SLOT_W;
   localparam int STORE_W = (8 * ID_CHARS < fcrr_pkg::ID_W) ? 8 * ID_CHARS : fcrr_pkg::ID_W;

   logic                          go;
   fcrr_pkg::fcrr_dec_type        dec;
   logic [SLOT_W-1:0]             slot;
   logic [STORE_W-1:0]            rd_data;
   logic                          pend_ff;
   logic                          pend_in;
   fcrr_pkg::fcrr_dec_type        pend_dec_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [fcrr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fcrr_pkg::STATUS_W-1:0] rsp_status_in;
   logic [fcrr_pkg::ID_W-1:0]     rsp_id_ff;
   logic [fcrr_pkg::ID_W-1:0]     rsp_id_in;
   logic [fcrr_pkg::CLASS_W-1:0]  rsp_class_ff;
   logic [fcrr_pkg::CLASS_W-1:0]  rsp_class_in;
   logic                          served;

   // request handshake
   assign req_ready = !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign go        = req_valid && req_ready;

   fcrr_sched #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_sched (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .mode        (req_mode),
      .queue_class (req_queue_class),
      .dec         (dec),
      .slot        (slot)
   );

   // entry memory addressed by class and slot
   fcrr_ram #(
      .WIDTH (STORE_W),
      .DEPTH (fcrr_pkg::CLASS_COUNT << SLOT_W)
   ) u_entries (
      .clock   (clock),
      .wr_en   (dec.wr_en),
      .rd_en   (dec.rd_en),
      .addr    (ADDR_W'({dec.cls, slot})),
      .wr_data (req_item_id[STORE_W-1:0]),
      .rd_data (rd_data)
   );

   // result assembly once the memory read lands
   assign served = (pend_dec_ff.status == fcrr_pkg::STAT_SERVED);

   always_comb begin
      pend_in       = go;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_class_in  = rsp_class_ff;
      if (pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_dec_ff.status;
         rsp_id_in     = served ? fcrr_pkg::ID_W'(rd_data) : '0;
         rsp_class_in  = served ? pend_dec_ff.cls : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         pend_dec_ff <= dec;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_class_ff  <= rsp_class_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_served_id    = rsp_id_ff;
   assign rsp_served_class = rsp_class_ff;

   // checks
   `FCRR_ASSERT_NXT(a_go_pends, clock, reset, go, pend_ff)
   `FCRR_ASSERT_NXT(a_pend_fills, clock, reset, pend_ff, rsp_valid_ff && !pend_ff)
   `FCRR_ASSERT_IMP(a_pend_blocks, clock, reset, pend_ff, !req_ready)
   `FCRR_ASSERT_IMP(a_id_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != fcrr_pkg::STAT_SERVED),
      (rsp_id_ff == '0) && (rsp_class_ff == '0))
endmodule
